/* hw/rtl/lru_frame_replacer_defines.svh */
// Assertion helpers shared by the replacer RTL.
`ifndef LRU_FRAME_REPLACER_DEFINES_SVH
`define LRU_FRAME_REPLACER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRUFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru_frame_replacer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LRUFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru_frame_replacer: next-cycle check failed");

`endif

/* hw/rtl/lrufr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lrufr_pkg;

    localparam int FRAME_W     = 6;
    localparam int COUNT_OUT_W = 7;

    localparam logic [1:0] OP_VICTIM = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_UNPIN  = 2'd2;
    localparam logic [1:0] OP_SIZE   = 2'd3;

    // Broadcast control for every cell of the chain.
    typedef struct packed {
        logic               shift_en;
        logic               append_en;
        logic [FRAME_W-1:0] frame;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hw/rtl/lrufr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrufr_cell
    import lrufr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic               i_left_occ,
    input  wire logic               i_shift_in,
    input  wire logic [FRAME_W-1:0] i_right_frame,
    input  wire logic               i_right_occ,
    output logic [FRAME_W-1:0]      o_frame,
    output logic                    o_occ,
    output logic                    o_shift_out
);

    logic [FRAME_W-1:0] r_frame;
    logic               r_occ;
    logic               w_match;
    logic               w_take_right;
    logic               w_append;

    assign w_match      = r_occ && (r_frame == i_ctl.frame);
    assign o_shift_out  = i_shift_in || w_match;
    // this cell and every cell after the removed one close the gap
    assign w_take_right = i_ctl.shift_en && o_shift_out;
    // first free cell takes the appended frame
    assign w_append     = i_ctl.append_en && i_left_occ && !r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (w_take_right) begin
            r_occ <= i_right_occ;
        end else if (w_append) begin
            r_occ <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_right) begin
            r_frame <= i_right_frame;
        end else if (w_append) begin
            r_frame <= i_ctl.frame;
        end
    end

    assign o_frame = r_frame;
    assign o_occ   = r_occ;

endmodule

`default_nettype wire

/* hw/rtl/lru_frame_replacer.sv */
// lru_frame_replacer: LRU list of unpinned frames held in a chain of FRAMES cells.
// The result item of an operation is registered and appears in the cycle after the item is accepted.
// Throughput: 1 item per cycle; every op is one compare-and-shift pass over the chain.
// A new item enters in the cycle the previous result leaves; a stalled result holds it off.
// Reset (i_rst_n low, synchronous): list empty, count zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none

`include "lru_frame_replacer_defines.svh"

module lru_frame_replacer
    import lrufr_pkg::*;
#(
    parameter int FRAMES = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_op,
    input  wire logic [FRAME_W-1:0]     i_frame,
    // result channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_found,
    output logic [FRAME_W-1:0]          o_evict_frame,
    output logic [COUNT_OUT_W-1:0]      o_listed_count
);

    localparam int CW = $clog2(FRAMES + 1);

    // ------------------------------------------------------------------
    // Handshake: the input only waits when a result is held and stalled.
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_out_take;

    assign o_stall    = o_valid && i_stall;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_take = o_valid && !i_stall;

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 holds the least recent frame; occupied cells
    // always form a contiguous prefix, so the first free cell is the
    // append slot and the last cell full means the list is full.
    // ------------------------------------------------------------------
    t_cell_ctl          w_ctl;
    logic [FRAME_W-1:0] w_cell_frame [FRAMES];
    logic [FRAMES-1:0]  w_occ;
    logic [FRAMES:0]    w_chain;

    logic w_is_victim;
    logic w_is_pin;
    logic w_is_unpin;
    logic w_frame_ok;
    logic w_listed;
    logic w_do_victim;
    logic w_do_pin;
    logic w_do_unpin;

    assign w_is_victim = (i_op == OP_VICTIM);
    assign w_is_pin    = (i_op == OP_PIN);
    assign w_is_unpin  = (i_op == OP_UNPIN);
    assign w_frame_ok  = (32'(i_frame) < 32'(FRAMES));

    // A victim seeds the shift at cell 0 so the whole list moves down.
    // For other ops the chain end is a plain "frame is listed" flag.
    assign w_chain[0] = w_is_victim;
    assign w_listed   = w_chain[FRAMES];

    assign w_do_victim = w_accept && w_is_victim && w_occ[0];
    assign w_do_pin    = w_accept && w_is_pin && w_frame_ok && w_listed;
    assign w_do_unpin  = w_accept && w_is_unpin && w_frame_ok && !w_listed
                         && !w_occ[FRAMES-1];

    assign w_ctl.shift_en  = w_do_victim || w_do_pin;
    assign w_ctl.append_en = w_do_unpin;
    assign w_ctl.frame     = i_frame;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic               w_left_occ;
        logic [FRAME_W-1:0] w_right_frame;
        logic               w_right_occ;

        if (g == 0) begin : g_head
            assign w_left_occ = 1'b1;
        end else begin : g_body
            assign w_left_occ = w_occ[g-1];
        end

        if (g == FRAMES - 1) begin : g_tail
            assign w_right_frame = '0;
            assign w_right_occ   = 1'b0;
        end else begin : g_link
            assign w_right_frame = w_cell_frame[g+1];
            assign w_right_occ   = w_occ[g+1];
        end

        lrufr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_occ    (w_left_occ),
            .i_shift_in    (w_chain[g]),
            .i_right_frame (w_right_frame),
            .i_right_occ   (w_right_occ),
            .o_frame       (w_cell_frame[g]),
            .o_occ         (w_occ[g]),
            .o_shift_out   (w_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Entry count
    // ------------------------------------------------------------------
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (w_ctl.shift_en) begin
            n_count = r_count - CW'(1);
        end else if (w_ctl.append_en) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                   r_valid;
    logic                   r_found;
    logic [FRAME_W-1:0]     r_victim;
    logic [COUNT_OUT_W-1:0] r_listed;
    logic [CW+COUNT_OUT_W-1:0] w_count_wide;

    // count field is the count modulo 2**COUNT_OUT_W
    assign w_count_wide = (CW + COUNT_OUT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_out_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found  <= w_do_victim;
            r_victim <= w_do_victim ? w_cell_frame[0] : '0;
            r_listed <= w_count_wide[COUNT_OUT_W-1:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_evict_frame  = r_victim;
    assign o_listed_count = r_listed;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // count tracks the number of occupied cells
    `LRUFR_ASSERT_IMPL(a_count_occ, 1'b1, 32'(r_count) == $countones(w_occ))
    // occupied cells stay a contiguous prefix
    `LRUFR_ASSERT_IMPL(a_occ_prefix, 1'b1, $onehot({1'b0, w_occ} + {{FRAMES{1'b0}}, 1'b1}))
    // a victim on a non-empty list shrinks it by one
    `LRUFR_ASSERT_NEXT(a_victim_dec, w_do_victim, r_count == $past(r_count) - CW'(1))
    // an unpin that appends grows the list by one
    `LRUFR_ASSERT_NEXT(a_unpin_inc, w_do_unpin, r_count == $past(r_count) + CW'(1))

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lrufr_pkg::*;

    localparam int FRAMES = 64;

    // One result item as the block returns it.
    typedef struct packed {
        logic                   found;
        logic [FRAME_W-1:0]     evict_frame;
        logic [COUNT_OUT_W-1:0] listed_count;
    } t_lru_result;

    // Shadow copy of the recency list plus the queue of results still owed by the block.
    class replacer_scoreboard;
        logic [FRAME_W-1:0] lru_list[$];          // index 0 is the least recently unpinned
        bit                 listed[FRAMES];
        t_lru_result        pending_results[$];
        int                 errors;
        int                 items_seen;
        int                 results_seen;
        int                 victims_found;
        int                 empty_victims;
        int                 full_hits;
        int                 peak_count;

        // Apply one accepted op to the shadow list and queue the result it owes.
        function void note_request(logic [1:0] op, logic [FRAME_W-1:0] frame);
            t_lru_result r;
            r = '0;
            case (op)
                OP_VICTIM: begin
                    if (lru_list.size() > 0) begin
                        r.found       = 1'b1;
                        r.evict_frame = lru_list.pop_front();
                        listed[r.evict_frame] = 1'b0;
                        victims_found++;
                    end else begin
                        empty_victims++;
                    end
                end
                OP_PIN: begin
                    if (listed[frame]) begin
                        for (int i = 0; i < lru_list.size(); i++) begin
                            if (lru_list[i] == frame) begin
                                lru_list.delete(i);
                                break;
                            end
                        end
                        listed[frame] = 1'b0;
                    end
                end
                OP_UNPIN: begin
                    // already listed: stays where it is
                    if (!listed[frame] && lru_list.size() < FRAMES) begin
                        lru_list.push_back(frame);
                        listed[frame] = 1'b1;
                    end
                end
                default: ;
            endcase
            r.listed_count = COUNT_OUT_W'(lru_list.size());
            items_seen++;
            if (lru_list.size() > peak_count)
                peak_count = lru_list.size();
            if (lru_list.size() == FRAMES)
                full_hits++;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic found, logic [FRAME_W-1:0] evict_frame,
                                   logic [COUNT_OUT_W-1:0] listed_count);
            t_lru_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected (found=%0d frame=%0d count=%0d)",
                         $time, found, evict_frame, listed_count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found) begin
                $display("%0t: found mismatch: expected %0d, got %0d",
                         $time, want.found, found);
                errors++;
            end
            if (evict_frame !== want.evict_frame) begin
                $display("%0t: evict_frame mismatch: expected %0d, got %0d",
                         $time, want.evict_frame, evict_frame);
                errors++;
            end
            if (listed_count !== want.listed_count) begin
                $display("%0t: listed_count mismatch: expected %0d, got %0d",
                         $time, want.listed_count, listed_count);
                errors++;
            end
        endfunction
    endclass

    // Block ports; all inputs start at known values.
    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic [1:0]             i_op    = OP_SIZE;
    logic [FRAME_W-1:0]     i_frame = '0;
    logic                   i_stall = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   o_found;
    logic [FRAME_W-1:0]     o_evict_frame;
    logic [COUNT_OUT_W-1:0] o_listed_count;

    // Idle rates in percent, changed per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    replacer_scoreboard sb = new();

    lru_frame_replacer #(
        .FRAMES(FRAMES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_frame        (i_frame),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_evict_frame  (o_evict_frame),
        .o_listed_count (o_listed_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stall, re-drawn every falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor: a result item moves on a rising edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_found, o_evict_frame, o_listed_count);
    end

    // Present one item starting at a falling edge, hold it until accepted.
    // Returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] op, input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_frame <= frame;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_request(op, frame);
        @(negedge i_clk);
    endtask

    // Sender holds off until every owed result has come back.
    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [FRAME_W-1:0] pick_listed();
        if (sb.lru_list.size() == 0)
            return FRAME_W'($urandom_range(FRAMES - 1));
        return sb.lru_list[$urandom_range(sb.lru_list.size() - 1)];
    endfunction

    function automatic logic [FRAME_W-1:0] pick_unlisted();
        int start;
        start = $urandom_range(FRAMES - 1);
        for (int i = 0; i < FRAMES; i++) begin
            if (!sb.listed[(start + i) % FRAMES])
                return FRAME_W'((start + i) % FRAMES);
        end
        return FRAME_W'(start);
    endfunction

    // Unpin every free frame in shuffled order until the list is full, then poke it.
    task automatic fill_to_full();
        int order[FRAMES];
        int j;
        int tmp;
        for (int i = 0; i < FRAMES; i++)
            order[i] = i;
        for (int i = FRAMES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < FRAMES; i++) begin
            if (!sb.listed[order[i]])
                send_item(OP_UNPIN, FRAME_W'(order[i]));
        end
        // full list: re-unpin is a no-op, pin then unpin moves a frame to the tail
        send_item(OP_UNPIN, pick_listed());
        send_item(OP_SIZE, FRAME_W'($urandom_range(FRAMES - 1)));
        j = pick_listed();
        send_item(OP_PIN, FRAME_W'(j));
        send_item(OP_UNPIN, FRAME_W'(j));
    endtask

    // Empty the list by victims with some pins mixed in, then one victim on empty.
    task automatic drain_to_empty();
        while (sb.lru_list.size() > 0) begin
            if ($urandom_range(99) < 70)
                send_item(OP_VICTIM, FRAME_W'($urandom_range(FRAMES - 1)));
            else
                send_item(OP_PIN, pick_listed());
        end
        send_item(OP_VICTIM, FRAME_W'($urandom_range(FRAMES - 1)));
    endtask

    // Random ops in segments that lean toward filling, draining or an even mix.
    task automatic run_mixed(input int count);
        int         mode;
        int         seg_left;
        int         r;
        logic [1:0] op;
        logic [FRAME_W-1:0] frame;
        seg_left = 0;
        mode     = 0;
        for (int n = 0; n < count; n++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(2);
                seg_left = $urandom_range(15, 40);
            end
            seg_left--;
            r = $urandom_range(99);
            case (mode)
                0:       op = (r < 70) ? OP_UNPIN : (r < 82) ? OP_PIN :
                              (r < 94) ? OP_VICTIM : OP_SIZE;
                1:       op = (r < 15) ? OP_UNPIN : (r < 50) ? OP_PIN :
                              (r < 90) ? OP_VICTIM : OP_SIZE;
                default: op = 2'($urandom_range(3));
            endcase
            frame = FRAME_W'($urandom_range(FRAMES - 1));
            if (op == OP_UNPIN && $urandom_range(99) < 70)
                frame = pick_unlisted();
            else if (op == OP_PIN && $urandom_range(99) < 70)
                frame = pick_listed();
            send_item(op, frame);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase 1: sender idles 23%, receiver stalls 49%.
        send_idle_pct  = 23;
        recv_stall_pct = 49;

        // Directed: empty-list cases, no-op unpin/pin, order kept across removals.
        send_item(OP_VICTIM, 6'd0);     // victim on empty list
        send_item(OP_SIZE,   6'd0);
        send_item(OP_PIN,    6'd5);     // pin of a frame that is not listed
        send_item(OP_UNPIN,  6'd0);
        send_item(OP_UNPIN,  6'd63);
        send_item(OP_UNPIN,  6'd0);     // already listed, keeps its place at the head
        send_item(OP_UNPIN,  6'd42);
        send_item(OP_SIZE,   6'd63);
        send_item(OP_PIN,    6'd63);    // removal from the middle
        send_item(OP_PIN,    6'd63);    // now unlisted
        send_item(OP_VICTIM, 6'd63);    // expect frame 0, frame field ignored
        send_item(OP_UNPIN,  6'd0);
        send_item(OP_VICTIM, 6'd0);     // expect 42
        send_item(OP_VICTIM, 6'd0);     // expect 0
        send_item(OP_VICTIM, 6'd0);     // empty again
        send_item(OP_PIN,    6'd0);
        send_item(OP_UNPIN,  6'd21);
        send_item(OP_UNPIN,  6'd42);
        send_item(OP_PIN,    6'd21);    // removal at the head
        send_item(OP_VICTIM, 6'd21);    // expect 42
        send_item(OP_SIZE,   6'd42);

        fill_to_full();
        run_mixed(110);
        wait_all_results();

        // Phase 2: roles swapped.
        send_idle_pct  = 49;
        recv_stall_pct = 23;
        run_mixed(170);
        wait_all_results();

        // Phase 3: no idling on either side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_to_full();
        drain_to_empty();
        run_mixed(80);
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(negedge i_clk);
        // keep watching the outputs so a stray extra result would still be caught
        repeat (8) @(negedge i_clk);

        if (sb.pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
            sb.errors++;
        end

        $display("Run covered %0d ops and %0d results: %0d victims returned, %0d on empty list.",
                 sb.items_seen, sb.results_seen, sb.victims_found, sb.empty_victims);
        $display("Peak listed count %0d, list full after %0d ops, %0d mismatches.",
                 sb.peak_count, sb.full_hits, sb.errors);
        if (sb.errors == 0)
            $display("** lru_frame_replacer: PASSED **");
        else
            $display("** lru_frame_replacer: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("%0t: timeout, %0d results still owed", $time, sb.pending_results.size());
        $display("** lru_frame_replacer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lrufr_pkg.sv
hw/rtl/lrufr_cell.sv
hw/rtl/lru_frame_replacer.sv
sim/tb_top.sv
